@@ hw/rtl/hcbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants of the chunked body decoder: result beat layout,
// status codes, framing characters and the hex digit decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

   localparam logic [2:0] ST_FRAME    = 3'd0;
   localparam logic [2:0] ST_PAYLOAD  = 3'd1;
   localparam logic [2:0] ST_COMPLETE = 3'd2;
   localparam logic [2:0] ST_ERROR    = 3'd3;
   localparam logic [2:0] ST_IGNORED  = 3'd4;

   localparam logic [7:0] LIMIT_RESET = 8'd100;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  out_byte;
      logic [31:0] body_length;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

@@ hw/rtl/hcbd_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_engine
// Framing state of the decoder. Each step consumes one byte, updates the
// size line, chunk and body counters and produces the result for that byte.
// ----------------------------------------------------------------------------
module hcbd_engine
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS  = 32,
   parameter int TOTAL_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] in_byte,
   input  logic [7:0] line_limit,
   output result_type result
);

   localparam logic [2:0] PH_SIZE     = 3'd0;
   localparam logic [2:0] PH_SIZE_LF  = 3'd1;
   localparam logic [2:0] PH_DATA     = 3'd2;
   localparam logic [2:0] PH_TRAIL_CR = 3'd3;
   localparam logic [2:0] PH_TRAIL_LF = 3'd4;
   localparam logic [2:0] PH_DONE     = 3'd5;
   localparam logic [2:0] PH_ERROR    = 3'd6;

   localparam logic [SIZE_BITS-1:0]  SIZE_ONE  = SIZE_BITS'(1);
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

   logic [2:0]            phase_ff, phase_in;
   logic [7:0]            line_count_ff, line_count_in;
   logic [SIZE_BITS-1:0]  size_accum_ff, size_accum_in;
   logic                  digit_seen_ff, digit_seen_in;
   logic                  digits_closed_ff, digits_closed_in;
   logic [SIZE_BITS-1:0]  chunk_left_ff, chunk_left_in;
   logic                  last_chunk_ff, last_chunk_in;
   logic [TOTAL_BITS-1:0] body_total_ff, body_total_in;
   logic [TOTAL_BITS+31:0] total_ext;
   hex_type               hex;
   logic [2:0]            status;
   logic [7:0]            out_byte;

   always_comb begin
      phase_in         = phase_ff;
      line_count_in    = line_count_ff;
      size_accum_in    = size_accum_ff;
      digit_seen_in    = digit_seen_ff;
      digits_closed_in = digits_closed_ff;
      chunk_left_in    = chunk_left_ff;
      last_chunk_in    = last_chunk_ff;
      body_total_in    = body_total_ff;
      status           = ST_FRAME;
      out_byte         = 8'd0;
      hex              = hex_decode(in_byte);

      unique case (phase_ff)
         PH_SIZE: begin
            priority if (in_byte == CHAR_CR) begin
               if (!digit_seen_ff) begin
                  phase_in = PH_ERROR;
                  status   = ST_ERROR;
               end else begin
                  phase_in = PH_SIZE_LF;
               end
            end else if (line_count_ff >= line_limit) begin
               phase_in = PH_ERROR;
               status   = ST_ERROR;
            end else begin
               line_count_in = line_count_ff + 8'd1;
               priority if (digits_closed_ff) begin
                  status = ST_FRAME;
               end else if (hex.ok) begin
                  if (size_accum_ff[SIZE_BITS-1 -: 4] != 4'd0) begin
                     phase_in = PH_ERROR;
                     status   = ST_ERROR;
                  end else begin
                     size_accum_in = {size_accum_ff[SIZE_BITS-5:0], hex.value};
                     digit_seen_in = 1'b1;
                  end
               end else if (in_byte == CHAR_SPACE || in_byte == CHAR_TAB) begin
                  if (digit_seen_ff) begin
                     digits_closed_in = 1'b1;
                  end
               end else if (in_byte == CHAR_SEMI && digit_seen_ff) begin
                  digits_closed_in = 1'b1;
               end else begin
                  phase_in = PH_ERROR;
                  status   = ST_ERROR;
               end
            end
         end
         PH_SIZE_LF: begin
            priority if (in_byte != CHAR_LF) begin
               phase_in = PH_ERROR;
               status   = ST_ERROR;
            end else if (size_accum_ff == '0) begin
               last_chunk_in = 1'b1;
               phase_in      = PH_TRAIL_CR;
            end else begin
               chunk_left_in = size_accum_ff;
               phase_in      = PH_DATA;
            end
         end
         PH_DATA: begin
            status   = ST_PAYLOAD;
            out_byte = in_byte;
            if (chunk_left_ff != '0) begin
               chunk_left_in = chunk_left_ff - SIZE_ONE;
            end
            if (body_total_ff != TOTAL_MAX) begin
               body_total_in = body_total_ff + TOTAL_BITS'(1);
            end
            if (chunk_left_ff <= SIZE_ONE) begin
               phase_in = PH_TRAIL_CR;
            end
         end
         PH_TRAIL_CR: begin
            if (in_byte != CHAR_CR) begin
               phase_in = PH_ERROR;
               status   = ST_ERROR;
            end else begin
               phase_in = PH_TRAIL_LF;
            end
         end
         PH_TRAIL_LF: begin
            priority if (in_byte != CHAR_LF) begin
               phase_in = PH_ERROR;
               status   = ST_ERROR;
            end else if (last_chunk_ff) begin
               phase_in = PH_DONE;
               status   = ST_COMPLETE;
            end else begin
               phase_in         = PH_SIZE;
               line_count_in    = 8'd0;
               size_accum_in    = '0;
               digit_seen_in    = 1'b0;
               digits_closed_in = 1'b0;
            end
         end
         PH_DONE: begin
            status = ST_IGNORED;
         end
         default: begin
            phase_in = PH_ERROR;
            status   = ST_ERROR;
         end
      endcase

      total_ext          = {32'd0, body_total_in};
      result.status      = status;
      result.out_byte    = out_byte;
      result.body_length = total_ext[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_SIZE;
         line_count_ff    <= 8'd0;
         size_accum_ff    <= '0;
         digit_seen_ff    <= 1'b0;
         digits_closed_ff <= 1'b0;
         chunk_left_ff    <= '0;
         last_chunk_ff    <= 1'b0;
         body_total_ff    <= '0;
      end else if (step) begin
         phase_ff         <= phase_in;
         line_count_ff    <= line_count_in;
         size_accum_ff    <= size_accum_in;
         digit_seen_ff    <= digit_seen_in;
         digits_closed_ff <= digits_closed_in;
         chunk_left_ff    <= chunk_left_in;
         last_chunk_ff    <= last_chunk_in;
         body_total_ff    <= body_total_in;
      end
   end

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR |=> phase_ff == PH_ERROR)
      else $error("error phase was left without reset");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |=> phase_ff == PH_DONE)
      else $error("end phase was left without reset");

   a_data_payload: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_DATA |-> result.status == ST_PAYLOAD)
      else $error("chunk data byte not reported as payload");

   a_total_grows: assert property (@(posedge clock) disable iff (reset)
      step |=> body_total_ff >= $past(body_total_ff))
      else $error("body total decreased");

endmodule

@@ hw/rtl/http_chunked_body_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes a chunked transfer body one byte per beat and returns one result
// beat per input byte: framing, payload, completion, error or ignored.
// Each accepted byte is held in the input stage, then its result in the result register.
// Throughput: one byte per cycle; the input stage and the result register
// advance together, so the only stall comes from rsp_ready.
// Reset clears the framing state, the body count and the pipeline, and sets
// the size line limit to 100.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS  = 32,
   parameter int TOTAL_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_out_byte,
   output logic [31:0] rsp_body_length,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type result;
   logic [7:0] limit_ff;
   logic       advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   hcbd_engine #(
      .SIZE_BITS  (SIZE_BITS),
      .TOTAL_BITS (TOTAL_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .in_byte    (in_byte_ff),
      .line_limit (limit_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_out_byte    = rsp_ff.out_byte;
   assign rsp_body_length = rsp_ff.body_length;

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input stage dropped a waiting byte");

   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result register not loaded on advance");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !advance)
      else $error("pending result overwritten");

endmodule
